// ===== rtl/core/ccfr_pkg.sv =====
`timescale 1ns / 1ps

package ccfr_pkg;

    localparam int MAX_FRAME_BYTES = 128;
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd10;
    localparam logic [7:0]  START_RESET     = 8'hA5;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'h0000;

    localparam int HDR_BYTES = 8;
    localparam int IDX_DEV   = 2;
    localparam int IDX_TYPE  = 3;
    localparam int IDX_SEQ   = 4;
    localparam int IDX_ECHO  = 5;
    localparam int IDX_LEN   = 7;
    localparam int IDX_CRCH  = 8;
    localparam int IDX_CRCL  = 9;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    function automatic t_addr wrap_add(input t_addr base, input t_count off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(MAX_FRAME_BYTES)) begin
            sum = sum - (CNT_W+1)'(MAX_FRAME_BYTES);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc_checked_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

// Length-framed byte receiver with CRC-16/XMODEM check.
// Slave stream: one received byte per item in s_tdata. Bytes are dropped
// until the start byte opens a window; byte 7 of the window gives the frame
// length (10..128), and the CRC over bytes 0-7 and 10..len-1 is compared with
// big-endian bytes 8-9.
// Master stream: one item per checked frame; tuser is 0 for an accepted frame
// and 1 for a checksum mismatch (oldest byte then dropped), tdata carries the
// header fields and both checksums.
// Config channel: writes the start byte; ready is always high.
// Rate: one byte at a time; bytes are taken only in the idle state. From
// byte 8 on, each byte is followed by a length check (states RD_LEN, LEN)
// that holds the input; a complete window is then walked through the window
// memory at one byte a cycle (FRONT, WALK), and the result item is loaded in
// REPORT, which waits while the master holds an item not yet taken. The
// single read port of the window memory sets this pace.
// Reset (synchronous, active low) empties the window, drops any pending
// item and restores the start byte to 0xA5.
// A stalled master holds the pending item; the next byte is still taken, and
// the block waits only when a second result is ready before the first left.
module crc_checked_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // frame_type, device_id, sequence_res, echoed_sequence,
                                     // frame_length, computed_crc, received_crc
    output logic        o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // start_byte
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD_LEN = 3'd1;
    localparam logic [2:0] ST_LEN    = 3'd2;
    localparam logic [2:0] ST_FRONT  = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;

    localparam ccfr_pkg::t_count OFF_LEN = ccfr_pkg::CNT_W'(ccfr_pkg::IDX_LEN);
    localparam ccfr_pkg::t_count OFF_ONE = ccfr_pkg::CNT_W'(1);
    localparam ccfr_pkg::t_count OFF_HDR = ccfr_pkg::CNT_W'(ccfr_pkg::HDR_BYTES);

    logic [2:0]             r_state;
    logic [7:0]             r_start_byte;
    ccfr_pkg::t_addr        r_start;
    ccfr_pkg::t_count       r_count;
    logic [7:0]             r_len;
    ccfr_pkg::t_count       r_rd_idx;
    logic                   r_dv;
    ccfr_pkg::t_addr        r_d_idx;
    logic [15:0]            r_crc;
    logic [7:0]             r_dev;
    logic [7:0]             r_type;
    logic [7:0]             r_seq;
    logic [7:0]             r_echo;
    logic [15:0]            r_given;
    logic                   r_m_valid;
    logic [71:0]            r_m_data;
    logic                   r_m_user;

    logic [7:0]             r_mem [ccfr_pkg::MAX_FRAME_BYTES];
    logic [7:0]             r_rdata;
    ccfr_pkg::t_addr        rd_addr;
    ccfr_pkg::t_addr        wr_addr;
    logic                   s_acc;
    logic                   wr_en;
    logic                   len_bad;
    logic                   crc_ok;
    logic                   out_free;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_user;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign wr_en    = s_acc && !(r_count == '0 && i_s_tdata != r_start_byte);
    assign wr_addr  = ccfr_pkg::wrap_add(r_start, r_count);
    assign len_bad  = (r_rdata < ccfr_pkg::MIN_FRAME_BYTES)
                   || ({1'b0, r_rdata} > 9'(ccfr_pkg::MAX_FRAME_BYTES));
    assign crc_ok   = (r_crc == r_given);
    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        case (r_state)
            ST_RD_LEN: rd_addr = ccfr_pkg::wrap_add(r_start, OFF_LEN);
            ST_LEN:    rd_addr = r_start;
            default:   rd_addr = ccfr_pkg::wrap_add(r_start, r_rd_idx);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_s_tdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start_byte <= ccfr_pkg::START_RESET;
            r_start      <= '0;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_dv         <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_byte <= i_cfg_data;
            end
            if (i_m_tready && r_state != ST_REPORT) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (wr_en) begin
                        r_count <= r_count + OFF_ONE;
                        if (r_count + OFF_ONE >= OFF_HDR) begin
                            r_state <= ST_RD_LEN;
                        end
                    end
                end
                ST_RD_LEN: begin
                    r_state <= ST_LEN;
                end
                ST_LEN: begin
                    r_len <= r_rdata;
                    if (len_bad) begin
                        r_count <= '0;
                        r_start <= '0;
                        r_state <= ST_IDLE;
                    end else if (8'(r_count) < r_rdata) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_FRONT;
                    end
                end
                ST_FRONT: begin
                    if (r_rdata != r_start_byte) begin
                        r_start <= ccfr_pkg::wrap_add(r_start, OFF_ONE);
                        r_count <= r_count - OFF_ONE;
                        r_state <= ST_IDLE;
                    end else begin
                        r_rd_idx <= '0;
                        r_dv     <= 1'b0;
                        r_crc    <= ccfr_pkg::CRC_INIT;
                        r_state  <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (8'(r_rd_idx) < r_len) begin
                        r_rd_idx <= r_rd_idx + OFF_ONE;
                        r_dv     <= 1'b1;
                        r_d_idx  <= r_rd_idx[ccfr_pkg::ADDR_W-1:0];
                    end else begin
                        r_dv <= 1'b0;
                        if (!r_dv) begin
                            r_state <= ST_REPORT;
                        end
                    end
                    if (r_dv) begin
                        case (r_d_idx)
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_DEV):  r_dev  <= r_rdata;
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_TYPE): r_type <= r_rdata;
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_SEQ):  r_seq  <= r_rdata;
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_ECHO): r_echo <= r_rdata;
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_CRCH): r_given[15:8] <= r_rdata;
                            ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_CRCL): r_given[7:0]  <= r_rdata;
                            default: ;
                        endcase
                        if (r_d_idx != ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_CRCH)
                            && r_d_idx != ccfr_pkg::ADDR_W'(ccfr_pkg::IDX_CRCL)) begin
                            r_crc <= ccfr_pkg::crc_feed(r_crc, r_rdata);
                        end
                    end
                end
                ST_REPORT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= !crc_ok;
                        r_m_data  <= {r_given, r_crc, r_len, r_echo, r_seq, r_dev, r_type};
                        if (crc_ok) begin
                            r_count <= '0;
                            r_start <= '0;
                        end else begin
                            r_start <= ccfr_pkg::wrap_add(r_start, OFF_ONE);
                            r_count <= r_count - OFF_ONE;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ccfr_pkg::CNT_W'(ccfr_pkg::MAX_FRAME_BYTES))
        else $error("window count above capacity");

    a_walk_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> (8'(r_count) >= r_len && 8'(r_rd_idx) <= r_len))
        else $error("walk over a window that is not complete");

    a_match_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && out_free && crc_ok) |=> (r_count == '0 && r_start == '0))
        else $error("accepted frame did not clear the window");

    a_report_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && out_free) |=> (r_m_valid && r_state == ST_IDLE))
        else $error("result not loaded");
`endif

endmodule

// ===== tb/crc_checked_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps

module crc_checked_frame_receiver_unit_tb;

    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES   = 160;

    typedef struct packed {
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic [7:0]  frame_length;
        logic [7:0]  echoed_sequence;
        logic [7:0]  sequence_res;
        logic [7:0]  device_id;
        logic [7:0]  frame_type;
    } t_hdr_word;

    typedef struct packed {
        logic      status;
        t_hdr_word word;
    } t_frame_report;

    typedef enum logic [1:0] {
        ROW_IGNORED,
        ROW_PREDICTED,
        ROW_CRC_HI,
        ROW_CRC_LO
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [20] = '{
        '{ROW_IGNORED,   8'h00}, '{ROW_IGNORED,   8'hFF},
        '{ROW_PREDICTED, 8'hA5}, '{ROW_PREDICTED, 8'hFF}, '{ROW_PREDICTED, 8'h00},
        '{ROW_PREDICTED, 8'hFF}, '{ROW_PREDICTED, 8'h00}, '{ROW_PREDICTED, 8'hFF},
        '{ROW_PREDICTED, 8'h00}, '{ROW_PREDICTED, 8'h0A},
        '{ROW_CRC_HI,    8'h00}, '{ROW_CRC_LO,    8'h00},
        '{ROW_PREDICTED, 8'hA5}, '{ROW_PREDICTED, 8'h00}, '{ROW_PREDICTED, 8'hFF},
        '{ROW_PREDICTED, 8'h00}, '{ROW_PREDICTED, 8'hFF}, '{ROW_PREDICTED, 8'h00},
        '{ROW_PREDICTED, 8'hFF}, '{ROW_IGNORED,   8'h81}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;     // data_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;     // frame_type, device_id, sequence_res, echoed_sequence,
                                // frame_length, computed_crc, received_crc
    logic        o_m_tuser;     // status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;    // start_byte

    logic [7:0]    win_mem [ccfr_pkg::MAX_FRAME_BYTES];
    int unsigned   win_head = 0;
    int unsigned   win_fill = 0;
    logic [7:0]    cur_start = ccfr_pkg::START_RESET;
    t_frame_report pending_reports [$];
    int            bytes_taken = 0;
    int            n_fail = 0;
    bit            quiet_run = 1'b0;
    bit            hold_off_req = 1'b0;

    crc_checked_frame_receiver_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ ccfr_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] win_byte(input int unsigned i);
        return win_mem[ccfr_pkg::ADDR_W'((win_head + i) % ccfr_pkg::MAX_FRAME_BYTES)];
    endfunction

    function automatic void drop_oldest();
        win_head = (win_head + 1) % ccfr_pkg::MAX_FRAME_BYTES;
        win_fill--;
    endfunction

    function automatic bit take_rx_byte(input logic [7:0] b, output t_frame_report rep);
        int unsigned flen;
        logic [15:0] crc;
        logic [15:0] carried;
        rep = '0;
        if (win_fill == 0 && b != cur_start) begin
            return 1'b0;
        end
        win_mem[ccfr_pkg::ADDR_W'((win_head + win_fill) % ccfr_pkg::MAX_FRAME_BYTES)] = b;
        win_fill++;
        if (win_fill < ccfr_pkg::HDR_BYTES) begin
            return 1'b0;
        end
        flen = {24'h0, win_byte(ccfr_pkg::IDX_LEN)};
        if (flen < ccfr_pkg::MIN_FRAME_BYTES || flen > ccfr_pkg::MAX_FRAME_BYTES) begin
            win_fill = 0;
            win_head = 0;
            return 1'b0;
        end
        if (win_fill < flen) begin
            return 1'b0;
        end
        if (win_byte(0) != cur_start) begin
            drop_oldest();
            return 1'b0;
        end
        crc = ccfr_pkg::CRC_INIT;
        for (int i = 0; i < flen; i++) begin
            if (i < ccfr_pkg::IDX_CRCH || i > ccfr_pkg::IDX_CRCL) begin
                crc = xmodem_update(crc, win_byte(i));
            end
        end
        carried = {win_byte(ccfr_pkg::IDX_CRCH), win_byte(ccfr_pkg::IDX_CRCL)};
        rep.status               = (crc != carried);
        rep.word.frame_type      = win_byte(ccfr_pkg::IDX_TYPE);
        rep.word.device_id       = win_byte(ccfr_pkg::IDX_DEV);
        rep.word.sequence_res    = win_byte(ccfr_pkg::IDX_SEQ);
        rep.word.echoed_sequence = win_byte(ccfr_pkg::IDX_ECHO);
        rep.word.frame_length    = flen[7:0];
        rep.word.computed_crc    = crc;
        rep.word.received_crc    = carried;
        if (crc == carried) begin
            win_fill = 0;
            win_head = 0;
        end else begin
            drop_oldest();
        end
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit none_expected);
        t_frame_report rep;
        bit            has_rep;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        if (win_fill != 0 || b == cur_start) begin
            bytes_taken++;
        end
        has_rep = take_rx_byte(b, rep);
        if (has_rep && !none_expected) begin
            pending_reports.insert(pending_reports.size(), rep);
        end
        if (!quiet_run && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [7:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_start = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length();
        int r;
        r = int'($urandom_range(0, 49));
        if (r == 0) begin
            return ccfr_pkg::MAX_FRAME_BYTES;
        end
        return (r < 6) ? int'($urandom_range(17, 60)) : int'($urandom_range(10, 16));
    endfunction

    task automatic emit_frame(input int flen, input bit spoil);
        logic [7:0]  fb [ccfr_pkg::MAX_FRAME_BYTES];
        logic [15:0] crc;
        fb[0] = cur_start;
        for (int i = 1; i < flen; i++) begin
            fb[i] = 8'($urandom_range(0, 255));
        end
        fb[ccfr_pkg::IDX_LEN] = 8'(flen);
        crc = ccfr_pkg::CRC_INIT;
        for (int i = 0; i < flen; i++) begin
            if (i < ccfr_pkg::IDX_CRCH || i > ccfr_pkg::IDX_CRCL) begin
                crc = xmodem_update(crc, fb[i]);
            end
        end
        if (spoil) begin
            crc ^= 16'(1 << $urandom_range(0, 15));
        end
        fb[ccfr_pkg::IDX_CRCH] = crc[15:8];
        fb[ccfr_pkg::IDX_CRCL] = crc[7:0];
        for (int i = 0; i < flen; i++) begin
            push_byte(fb[i], 1'b0);
        end
    endtask

    // feed bad length bytes until the window empties
    task automatic resync();
        logic [7:0] filler;
        int         guard;
        filler = (cur_start == 8'h00) ? 8'hFF : 8'h00;
        guard  = 0;
        while (win_fill != 0 && guard < 400) begin
            push_byte(filler, 1'b0);
            guard++;
        end
    endtask

    task automatic run_traffic(input int n_items);
        int goal;
        int pick;
        goal = bytes_taken + n_items;
        while (bytes_taken < goal) begin
            if (win_fill != 0 && $urandom_range(0, 2) != 0) begin
                resync();
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 70) begin
                emit_frame(pick_length(), 1'b0);
            end else if (pick < 82) begin
                emit_frame(pick_length(), 1'b1);
            end else if (pick < 92) begin
                push_byte(cur_start, 1'b0);
                repeat (6) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 9))
                                               : 8'($urandom_range(129, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    push_byte(($urandom_range(0, 3) == 0) ? cur_start
                                                          : 8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
    endtask

    // leave a partial frame under the old start byte, then retarget
    task automatic retarget_start(input logic [7:0] v);
        push_byte(cur_start, 1'b0);
        repeat (2) push_byte(8'($urandom_range(0, 255)), 1'b0);
        write_start_byte(v);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    initial begin
        t_frame_report want;
        t_hdr_word     got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = t_hdr_word'(o_m_tdata);
                if (pending_reports.size() == 0) begin
                    $error("unexpected result: status %0h, data %h", o_m_tuser, o_m_tdata);
                    n_fail++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("status", 16'(want.status), 16'(o_m_tuser));
                    check_field("frame_type", 16'(want.word.frame_type), 16'(got.frame_type));
                    check_field("device_id", 16'(want.word.device_id), 16'(got.device_id));
                    check_field("sequence_res", 16'(want.word.sequence_res),
                                16'(got.sequence_res));
                    check_field("echoed_sequence", 16'(want.word.echoed_sequence),
                                16'(got.echoed_sequence));
                    check_field("frame_length", 16'(want.word.frame_length),
                                16'(got.frame_length));
                    check_field("computed_crc", want.word.computed_crc, got.computed_crc);
                    check_field("received_crc", want.word.received_crc, got.received_crc);
                end
            end
        end
    end

    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        logic [15:0] frame_crc;
        logic [7:0]  b;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        frame_crc = ccfr_pkg::CRC_INIT;
        foreach (DIRECTED_ROWS[r]) begin
            case (DIRECTED_ROWS[r].kind)
                ROW_CRC_HI: b = frame_crc[15:8];
                ROW_CRC_LO: b = frame_crc[7:0];
                default:    b = DIRECTED_ROWS[r].data;
            endcase
            push_byte(b, DIRECTED_ROWS[r].kind == ROW_IGNORED);
            if (DIRECTED_ROWS[r].kind == ROW_IGNORED) begin
                frame_crc = ccfr_pkg::CRC_INIT;
            end else if (DIRECTED_ROWS[r].kind == ROW_PREDICTED) begin
                frame_crc = xmodem_update(frame_crc, b);
            end
        end

        run_traffic(170);

        // hold the result output off while frames keep arriving
        retarget_start(8'h00);
        hold_off_req = 1'b1;
        run_traffic(90);
        resync();
        emit_frame(ccfr_pkg::MAX_FRAME_BYTES, 1'b0);
        run_traffic(90);

        retarget_start(8'hFF);
        run_traffic(90);
        drain_results();
        run_traffic(90);

        retarget_start(8'($urandom_range(0, 255)));
        run_traffic(170);

        retarget_start(ccfr_pkg::START_RESET);
        quiet_run = 1'b1;
        run_traffic(170);

        drain_results();
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
